/* src/triangle_jacobian_inverse_macros.svh */
// Assertion helpers for the triangle Jacobian block.
`ifndef TRIANGLE_JACOBIAN_INVERSE_MACROS_SVH
`define TRIANGLE_JACOBIAN_INVERSE_MACROS_SVH

// Same-cycle implication.
`define TJI_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tji assertion failed");

// Next-cycle implication.
`define TJI_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tji assertion failed");

`endif

/* src/tji_pkg.sv */
package tji_pkg;

  localparam int IDX_W     = 10;
  localparam int ELEM_W    = 16;
  localparam int JAC_LAT   = 3;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } node_t;

  typedef struct packed {
    logic signed [31:0] j11;
    logic signed [31:0] j12;
    logic signed [31:0] j21;
    logic signed [31:0] j22;
    logic signed [63:0] det;
  } jac_t;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

/* src/tji_ifs.sv */
interface tji_in_if import tji_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [IDX_W-1:0]   node_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic [IDX_W-1:0]   vertex_a;
  logic [IDX_W-1:0]   vertex_b;
  logic [IDX_W-1:0]   vertex_c;

  modport source (output valid, kind, node_index, coord_x, coord_y,
                  vertex_a, vertex_b, vertex_c, input ready);
  modport sink   (input valid, kind, node_index, coord_x, coord_y,
                  vertex_a, vertex_b, vertex_c, output ready);
endinterface

interface tji_out_if import tji_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ELEM_W-1:0]  element_index;
  logic signed [31:0] jac_11;
  logic signed [31:0] jac_12;
  logic signed [31:0] jac_21;
  logic signed [31:0] jac_22;
  logic signed [63:0] determinant;
  logic signed [31:0] inv_11;
  logic signed [31:0] inv_12;
  logic signed [31:0] inv_21;
  logic signed [31:0] inv_22;
  logic               degenerate;

  modport source (output valid, element_index, jac_11, jac_12, jac_21, jac_22,
                  determinant, inv_11, inv_12, inv_21, inv_22, degenerate,
                  input ready);
  modport sink   (input valid, element_index, jac_11, jac_12, jac_21, jac_22,
                  determinant, inv_11, inv_12, inv_21, inv_22, degenerate,
                  output ready);
endinterface

/* src/tji_node_store.sv */
module tji_node_store import tji_pkg::*; #(
  parameter int NODE_COUNT = 1024
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  node_t                 wr_node,
  input  logic [2:0][IDX_W-1:0] rd_idx,
  output node_t [2:0]           rd_node
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [IW-1:0] wr_ext;
  logic          wr_ok;

  assign wr_ext = IW'(wr_idx);
  assign wr_ok  = wr_ext < IW'(NODE_COUNT);

  // one copy per read port, all written alike
  for (genvar r = 0; r < 3; r++) begin : g_copy
    node_t         mem [NODE_COUNT];
    node_t         q_r;
    logic          ok_r;
    logic [IW-1:0] rd_ext;

    assign rd_ext = IW'(rd_idx[r]);

    always_ff @(posedge clk) begin
      if (wr_en && wr_ok) begin
        mem[wr_ext[AW-1:0]] <= wr_node;
      end
      if (en) begin
        q_r  <= mem[rd_ext[AW-1:0]];
        ok_r <= rd_ext < IW'(NODE_COUNT);
      end
    end

    assign rd_node[r] = ok_r ? q_r : '0;
  end

endmodule

/* src/tji_jacobian.sv */
module tji_jacobian import tji_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  node_t [2:0] node,
  output jac_t        jac
);

  logic signed [32:0] d11, d12, d21, d22;
  logic signed [31:0] j11_r, j12_r, j21_r, j22_r;
  logic signed [31:0] j11_b_r, j12_b_r, j21_b_r, j22_b_r;
  logic signed [63:0] p1_r, p2_r, p1_nxt, p2_nxt;
  jac_t               jac_r;

  assign d11 = 33'(node[1].x) - 33'(node[0].x);
  assign d12 = 33'(node[2].x) - 33'(node[0].x);
  assign d21 = 33'(node[1].y) - 33'(node[0].y);
  assign d22 = 33'(node[2].y) - 33'(node[0].y);

  assign p1_nxt = j11_r * j22_r;
  assign p2_nxt = j12_r * j21_r;

  always_ff @(posedge clk) begin
    if (en) begin
      // floor halving
      j11_r <= d11[32:1];
      j12_r <= d12[32:1];
      j21_r <= d21[32:1];
      j22_r <= d22[32:1];

      j11_b_r <= j11_r;
      j12_b_r <= j12_r;
      j21_b_r <= j21_r;
      j22_b_r <= j22_r;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;

      jac_r.j11 <= j11_b_r;
      jac_r.j12 <= j12_b_r;
      jac_r.j21 <= j21_b_r;
      jac_r.j22 <= j22_b_r;
      jac_r.det <= p1_r - p2_r;
    end
  end

  assign jac = jac_r;

endmodule

/* src/tji_divider.sv */
module tji_divider import tji_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               neg,
  input  logic [31:0]        mag,
  input  logic [63:0]        det,
  output logic signed [31:0] quot
);

  // (mag << 32) / det, one quotient bit per stage
  logic [63:0]          rem_r   [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_r   [DIV_STEPS+1];
  logic [63:0]          det_r   [DIV_STEPS+1];
  logic                 neg_r   [DIV_STEPS+1];
  logic                 big_r   [DIV_STEPS+1];
  logic [63:0]          rem_nxt [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_nxt [DIV_STEPS+1];
  logic [64:0]          sh      [DIV_STEPS+1];
  logic                 ge      [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q;

  always_comb begin
    sh[0]      = '0;
    ge[0]      = 1'b0;
    rem_nxt[0] = 64'(mag);
    quo_nxt[0] = '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      sh[k]      = {rem_r[k-1], 1'b0};
      ge[k]      = sh[k] >= {1'b0, det_r[k-1]};
      rem_nxt[k] = ge[k] ? 64'(sh[k] - {1'b0, det_r[k-1]}) : sh[k][63:0];
      quo_nxt[k] = {quo_r[k-1][DIV_STEPS-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r[0] <= det;
      neg_r[0] <= neg;
      big_r[0] <= 64'(mag) >= det;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
        det_r[k] <= det_r[k-1];
        neg_r[k] <= neg_r[k-1];
        big_r[k] <= big_r[k-1];
      end
    end
  end

  assign q = quo_r[DIV_STEPS];

  always_comb begin
    if (neg_r[DIV_STEPS]) begin
      quot = (big_r[DIV_STEPS] || q > SAT_NEG) ? $signed(SAT_NEG) : $signed(-q);
    end else begin
      quot = (big_r[DIV_STEPS] || q[DIV_STEPS-1]) ? $signed(SAT_POS) : $signed(q);
    end
  end

endmodule

/* src/triangle_jacobian_inverse.sv */
// Triangle affine Jacobian and inverse, Q16.16 fixed point.
// in_ch: a node word (kind 0) stores x,y at node_index; a triangle word
// (kind 1) reads vertices vertex_a/b/c and yields one out_ch word.
// out_ch: Jacobian (halved edge differences), Q32.32 determinant and the
// inverse Jacobian, truncated toward zero and saturated; a determinant of
// zero or less sets degenerate and zeroes the inverse.
// Throughput: one word per cycle unless out_ch stalls, node and triangle words alike.
// A triangle word goes from acceptance through the node read, the Jacobian/multiply/determinant
// stages, the 33-stage divider and the output register to out_ch.valid.
// A node word may be followed at once by a triangle word that reads it.
// Reset clears the valid bits (output valid among them) and the triangle count;
// node contents are not cleared and must be written before they are read.
// When out_ch.ready is low with a word pending, the whole pipeline holds
// and in_ch.ready drops in the same cycle.
`include "triangle_jacobian_inverse_macros.svh"

module triangle_jacobian_inverse import tji_pkg::*; #(
  parameter int NODE_COUNT = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  tji_in_if.sink    in_ch,
  tji_out_if.source out_ch
);

  logic                  en, acc, tri_acc, node_acc;
  logic [ELEM_W-1:0]     count_r;
  logic [2:0][IDX_W-1:0] rd_idx;
  node_t [2:0]           nodes;
  node_t                 wr_node;
  jac_t                  jac;
  logic                  degen;
  logic signed [31:0]    quot [4];
  logic [3:0]            div_neg;
  logic [31:0]           div_mag [4];

  logic                  v_j_r   [JAC_LAT+1];
  logic [ELEM_W-1:0]     idx_j_r [JAC_LAT+1];
  logic                  v_d_r   [DIV_LAT];
  logic [ELEM_W-1:0]     idx_d_r [DIV_LAT];
  jac_t                  jac_d_r [DIV_LAT];
  logic                  deg_d_r [DIV_LAT];

  logic                  out_valid_r;
  logic [ELEM_W-1:0]     out_idx_r;
  jac_t                  out_jac_r;
  logic [3:0][31:0]      out_inv_r;
  logic                  out_degen_r;

  assign en       = !out_valid_r || out_ch.ready;
  assign acc      = in_ch.valid && en;
  assign tri_acc  = acc && (in_ch.kind == KIND_TRI);
  assign node_acc = acc && (in_ch.kind == KIND_NODE);
  assign in_ch.ready = en;

  assign rd_idx    = {in_ch.vertex_c, in_ch.vertex_b, in_ch.vertex_a};
  assign wr_node.x = in_ch.coord_x;
  assign wr_node.y = in_ch.coord_y;

  tji_node_store #(.NODE_COUNT(NODE_COUNT)) u_store (
    .clk     (clk),
    .en      (en),
    .wr_en   (node_acc),
    .wr_idx  (in_ch.node_index),
    .wr_node (wr_node),
    .rd_idx  (rd_idx),
    .rd_node (nodes)
  );

  tji_jacobian u_jac (
    .clk  (clk),
    .en   (en),
    .node (nodes),
    .jac  (jac)
  );

  assign degen = jac.det <= 64'sd0;

  // adjugate: j22, -j12, -j21, j11
  assign div_neg    = {jac.j11 < 0, jac.j21 > 0, jac.j12 > 0, jac.j22 < 0};
  assign div_mag[0] = abs32(jac.j22);
  assign div_mag[1] = abs32(jac.j12);
  assign div_mag[2] = abs32(jac.j21);
  assign div_mag[3] = abs32(jac.j11);

  for (genvar i = 0; i < 4; i++) begin : g_div
    tji_divider u_div (
      .clk  (clk),
      .en   (en),
      .neg  (div_neg[i]),
      .mag  (div_mag[i]),
      .det  (jac.det),
      .quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= JAC_LAT; k++) v_j_r[k] <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) v_d_r[k] <= 1'b0;
    end else if (en) begin
      if (tri_acc) begin
        count_r <= count_r + 16'd1;
      end
      v_j_r[0] <= tri_acc;
      for (int k = 1; k <= JAC_LAT; k++) v_j_r[k] <= v_j_r[k-1];
      v_d_r[0] <= v_j_r[JAC_LAT];
      for (int k = 1; k < DIV_LAT; k++) v_d_r[k] <= v_d_r[k-1];
      out_valid_r <= v_d_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_j_r[0] <= count_r;
      for (int k = 1; k <= JAC_LAT; k++) idx_j_r[k] <= idx_j_r[k-1];
      idx_d_r[0] <= idx_j_r[JAC_LAT];
      jac_d_r[0] <= jac;
      deg_d_r[0] <= degen;
      for (int k = 1; k < DIV_LAT; k++) begin
        idx_d_r[k] <= idx_d_r[k-1];
        jac_d_r[k] <= jac_d_r[k-1];
        deg_d_r[k] <= deg_d_r[k-1];
      end
      out_idx_r   <= idx_d_r[DIV_LAT-1];
      out_jac_r   <= jac_d_r[DIV_LAT-1];
      out_degen_r <= deg_d_r[DIV_LAT-1];
      for (int i = 0; i < 4; i++) begin
        out_inv_r[i] <= deg_d_r[DIV_LAT-1] ? 32'd0 : 32'(quot[i]);
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.element_index = out_idx_r;
  assign out_ch.jac_11        = out_jac_r.j11;
  assign out_ch.jac_12        = out_jac_r.j12;
  assign out_ch.jac_21        = out_jac_r.j21;
  assign out_ch.jac_22        = out_jac_r.j22;
  assign out_ch.determinant   = out_jac_r.det;
  assign out_ch.inv_11        = $signed(out_inv_r[0]);
  assign out_ch.inv_12        = $signed(out_inv_r[1]);
  assign out_ch.inv_21        = $signed(out_inv_r[2]);
  assign out_ch.inv_22        = $signed(out_inv_r[3]);
  assign out_ch.degenerate    = out_degen_r;

  `TJI_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid_r && out_degen_r, out_inv_r == '0)
  `TJI_ASSERT_IMP(a_det_pos, clk, rst_n, out_valid_r && !out_degen_r, out_jac_r.det > 64'sd0)
  `TJI_ASSERT_NXT(a_count, clk, rst_n, tri_acc, count_r == $past(count_r) + 16'd1)
  `TJI_ASSERT_NXT(a_stall, clk, rst_n, !en, $stable(v_d_r[DIV_LAT-1]) && out_valid_r)

endmodule

/* tb/sv/triangle_jacobian_inverse_tb.sv */
`timescale 1ns / 100ps

module triangle_jacobian_inverse_tb;
  import tji_pkg::*;

  typedef struct {
    logic        kind;
    logic [9:0]  node_index;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [9:0]  vertex_a;
    logic [9:0]  vertex_b;
    logic [9:0]  vertex_c;
  } mesh_word_t;

  typedef struct packed {
    logic [15:0] element_index;
    logic [31:0] j11, j12, j21, j22;
    logic [63:0] det;
    logic [31:0] i11, i12, i21, i22;
    logic        degenerate;
  } element_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tji_in_if  in_ch();
  tji_out_if out_ch();

  triangle_jacobian_inverse u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mesh_word_t pending_words[$];
  element_t   expected_elements[$];
  logic signed [31:0] mdl_x[1024];
  logic signed [31:0] mdl_y[1024];
  bit         node_written[1024];
  logic [15:0] elem_count = 16'd0;
  int errors = 0;
  int n_tri = 0;
  int n_degen = 0;
  int n_sat = 0;
  int n_checked = 0;
  bit stim_done = 1'b0;
  bit hold_long = 1'b0;

  function automatic logic [31:0] inv_q16(logic signed [63:0] adj, logic signed [63:0] det);
    logic [63:0] mag;
    logic [95:0] q;
    mag = adj < 0 ? 64'(-adj) : 64'(adj);
    q = {mag, 32'd0} / {32'd0, det};
    if (adj < 0) begin
      if (q > 96'h8000_0000) q = 96'h8000_0000;
      return 32'(-q[63:0]);
    end
    if (q > 96'h7fff_ffff) q = 96'h7fff_ffff;
    return q[31:0];
  endfunction

  task automatic predict_word(input mesh_word_t w);
    logic signed [63:0] xa, ya, xb, yb, xc, yc, dx;
    element_t e;
    if (w.kind == KIND_NODE) begin
      mdl_x[w.node_index] = w.coord_x;
      mdl_y[w.node_index] = w.coord_y;
      return;
    end
    xa = mdl_x[w.vertex_a]; ya = mdl_y[w.vertex_a];
    xb = mdl_x[w.vertex_b]; yb = mdl_y[w.vertex_b];
    xc = mdl_x[w.vertex_c]; yc = mdl_y[w.vertex_c];
    dx = (xb - xa) >>> 1; e.j11 = dx[31:0];
    dx = (xc - xa) >>> 1; e.j12 = dx[31:0];
    dx = (yb - ya) >>> 1; e.j21 = dx[31:0];
    dx = (yc - ya) >>> 1; e.j22 = dx[31:0];
    e.det = $signed(e.j11) * $signed(e.j22) - $signed(e.j12) * $signed(e.j21);
    e.degenerate = $signed(e.det) <= 0;
    e.i11 = 0; e.i12 = 0; e.i21 = 0; e.i22 = 0;
    if (!e.degenerate) begin
      e.i11 = inv_q16(64'($signed(e.j22)), e.det);
      e.i12 = inv_q16(-64'($signed(e.j12)), e.det);
      e.i21 = inv_q16(-64'($signed(e.j21)), e.det);
      e.i22 = inv_q16(64'($signed(e.j11)), e.det);
      if (e.i11 == SAT_POS || e.i11 == SAT_NEG || e.i22 == SAT_POS) n_sat++;
    end else n_degen++;
    e.element_index = elem_count;
    elem_count++;
    n_tri++;
    expected_elements.push_back(e);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_node(input int idx, input logic [31:0] x, input logic [31:0] y);
    mesh_word_t w;
    w = '{KIND_NODE, 10'(idx), x, y, 10'($urandom), 10'($urandom), 10'($urandom)};
    node_written[idx] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic add_tri(input int a, input int b, input int c);
    mesh_word_t w;
    w = '{KIND_TRI, 10'($urandom), $urandom, $urandom, 10'(a), 10'(b), 10'(c)};
    pending_words.push_back(w);
  endtask

  function automatic int pick_written();
    int k;
    do k = $urandom_range(0, 1023); while (!node_written[k]);
    return k;
  endfunction

  initial begin
    int a, b, c;
    add_node(0, 32'h0000_0000, 32'h0000_0000);
    add_node(1, 32'h0002_0000, 32'h0000_0000);
    add_node(2, 32'h0000_0000, 32'h0002_0000);
    add_node(1023, 32'h7fff_ffff, 32'h7fff_ffff);
    add_node(512, 32'h8000_0000, 32'h8000_0000);
    add_node(3, 32'h7fff_ffff, 32'h8000_0000);
    add_node(4, 32'h8000_0000, 32'h7fff_ffff);
    add_node(5, 32'h0000_0001, 32'h0000_0000);
    add_node(6, 32'h0000_0000, 32'h0000_0001);
    add_tri(0, 1, 2);
    add_tri(0, 2, 1);
    add_tri(0, 0, 0);
    add_tri(512, 3, 4);
    add_tri(512, 4, 3);
    add_tri(1023, 512, 3);
    add_tri(0, 5, 6);
    add_tri(0, 1, 1023);
    add_tri(4, 1023, 512);
    add_node(7, 32'h0001_0000, 32'h0001_0000);
    add_tri(0, 1, 7);
    add_tri(3, 4, 0);
    for (int i = 0; i < 680; i++) begin
      if (i < 40 || $urandom_range(0, 2) == 0)
        add_node($urandom_range(0, 1023), rand_coord(), rand_coord());
      else begin
        a = pick_written(); b = pick_written(); c = pick_written();
        add_tri(a, b, c);
      end
    end
  end

  // driver
  int gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= 1'b0; in_ch.node_index <= '0;
      in_ch.coord_x <= '0; in_ch.coord_y <= '0;
      in_ch.vertex_a <= '0; in_ch.vertex_b <= '0; in_ch.vertex_c <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_word('{in_ch.kind, in_ch.node_index, in_ch.coord_x, in_ch.coord_y,
                       in_ch.vertex_a, in_ch.vertex_b, in_ch.vertex_c});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          mesh_word_t w;
          w = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= w.kind; in_ch.node_index <= w.node_index;
          in_ch.coord_x <= w.coord_x; in_ch.coord_y <= w.coord_y;
          in_ch.vertex_a <= w.vertex_a; in_ch.vertex_b <= w.vertex_b;
          in_ch.vertex_c <= w.vertex_c;
          if ($urandom_range(0, 3) == 0)
            gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        end else begin
          in_ch.valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls the input
  initial begin
    @(posedge rst_n);
    repeat (300) @(posedge clk);
    hold_long = 1'b1;
    repeat (200) @(posedge clk);
    hold_long = 1'b0;
  end

  int stall = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        element_t g, e;
        g = '{out_ch.element_index, out_ch.jac_11, out_ch.jac_12, out_ch.jac_21,
              out_ch.jac_22, out_ch.determinant, out_ch.inv_11, out_ch.inv_12,
              out_ch.inv_21, out_ch.inv_22, out_ch.degenerate};
        if (expected_elements.size() == 0) begin
          $display("%0t: unexpected element, actual %p", $time, g);
          errors++;
        end else begin
          e = expected_elements.pop_front();
          n_checked++;
          if (g !== e) begin
            $display("%0t: element mismatch, expected %p, actual %p", $time, e, g);
            errors++;
          end
        end
      end
      if (hold_long) begin
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_elements.size() == 0);
    repeat (100) @(posedge clk);
    $display("Checked %0d triangles (%0d degenerate, %0d with saturated inverse).",
             n_checked, n_degen, n_sat);
    if (errors == 0 && expected_elements.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d elements outstanding", expected_elements.size());
    $display("Test completed with failures");
    $finish;
  end
endmodule
